// ===== src/ipv6_l4_checksum_checker_core_macros.svh =====
// ----------------------------------------------------------------------------
// IPv6 L4 checksum checker assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef IPV6_L4_CHECKSUM_CHECKER_CORE_MACROS_SVH
`define IPV6_L4_CHECKSUM_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define IP6CS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define IP6CS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Holds in the cycle after reset is seen.
`define IP6CS_ASSERT_RESET(lbl, clk, rst, cons, msg) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== src/ip6cs_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv6 L4 checksum checker package
// Transaction types, protocol constants and ones-complement helpers.
// ----------------------------------------------------------------------------
package ip6cs_pkg;

  localparam logic [7:0]  PROTO_UDP   = 8'h11;
  localparam logic [7:0]  PROTO_ICMP6 = 8'h3a;
  localparam logic [15:0] ALL_ONES    = 16'hffff;
  localparam logic [16:0] POS_MAX     = 17'h1ffff;

  // Byte positions within the packet
  localparam int HDR_LEN        = 40;
  localparam int POS_PLEN_HI    = 4;
  localparam int POS_PLEN_LO    = 5;
  localparam int POS_NEXT_HDR   = 6;
  localparam int POS_ADDR_START = 8;
  localparam int POS_ICMP_CS_HI = 42;
  localparam int POS_ICMP_CS_LO = 43;
  localparam int POS_UDP_LEN_HI = 44;
  localparam int POS_UDP_LEN_LO = 45;
  localparam int POS_UDP_CS_HI  = 46;
  localparam int POS_UDP_CS_LO  = 47;
  localparam int UDP_MIN_LEN    = 8;
  localparam int ICMP_MIN_LEN   = 4;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [2:0] ST_MATCH       = 3'd0;
  localparam logic [2:0] ST_MISMATCH    = 3'd1;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
  localparam logic [2:0] ST_TRUNCATED   = 3'd3;
  localparam logic [2:0] ST_SHORT_UDP   = 3'd4;

  localparam logic [1:0] KIND_UDP   = 2'd0;
  localparam logic [1:0] KIND_ICMP6 = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  localparam logic [5:0] OFFSET_UDP   = 6'd46;
  localparam logic [5:0] OFFSET_ICMP6 = 6'd42;
  localparam logic [5:0] OFFSET_NONE  = 6'd0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] computed_checksum;
    logic [15:0] stored_checksum;
    logic [2:0]  check_status;
    logic [1:0]  transport_kind;
    logic [5:0]  checksum_offset;
  } out_item_t;

  // Per-packet summary handed from the front to the back
  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  offset;
    logic [2:0]  status;
    logic [15:0] sum;
    logic [15:0] pseudo_len;
    logic [15:0] stored;
  } summary_t;

  // Two 16-bit terms need a single end-around fold
  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

  function automatic logic [1:0] kind_of(logic [7:0] nh);
    logic [1:0] k;
    if (nh == PROTO_UDP) k = KIND_UDP;
    else if (nh == PROTO_ICMP6) k = KIND_ICMP6;
    else k = KIND_OTHER;
    return k;
  endfunction

  function automatic logic in_sum(logic [17:0] pos, logic [1:0] kind,
                                  logic [15:0] udp_len, logic [15:0] ip_len);
    logic [17:0] udp_end;
    logic [17:0] ip_end;
    logic        r;
    udp_end = 18'(HDR_LEN) + {2'b00, udp_len};
    ip_end  = 18'(HDR_LEN) + {2'b00, ip_len};
    if (pos < 18'(POS_ADDR_START)) r = 1'b0;
    else if (pos < 18'(HDR_LEN)) r = 1'b1;
    else if (kind == KIND_UDP) begin
      if (pos < 18'(POS_UDP_CS_HI)) r = 1'b1;
      else if (pos <= 18'(POS_UDP_CS_LO)) r = 1'b0;
      else r = (pos < udp_end);
    end else if (kind == KIND_ICMP6) begin
      if (pos == 18'(POS_ICMP_CS_HI) || pos == 18'(POS_ICMP_CS_LO)) r = 1'b0;
      else r = (pos < ip_end);
    end else r = 1'b0;
    return r;
  endfunction

endpackage

// ===== src/ip6cs_front.sv =====
// ----------------------------------------------------------------------------
// IPv6 L4 checksum checker front end
// Tracks byte position, captures header fields, accumulates the sum and
// classifies the packet into a summary at its last byte.
// ----------------------------------------------------------------------------
module ip6cs_front import ip6cs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  output logic     q_push,
  output summary_t q_data
);

  logic [16:0] pos;
  logic [15:0] run_sum;
  logic [7:0]  held_hi;
  logic [7:0]  nh;
  logic [15:0] ipl;
  logic [15:0] udpl;
  logic [15:0] found;

  logic [16:0] pos_next;
  logic [15:0] run_sum_next;
  logic [7:0]  held_hi_next;
  logic [7:0]  nh_next;
  logic [15:0] ipl_next;
  logic [15:0] udpl_next;
  logic [15:0] found_next;

  logic [17:0] pos_ext;
  logic [17:0] pos_inc;
  logic [17:0] udp_end;
  logic [17:0] ip_end;
  logic [1:0]  kind;
  logic        cur_in;
  logic        nxt_in;
  logic        add_en;
  logic [15:0] addend;
  logic [7:0]  b;
  summary_t    rec;

  assign b       = item.data_byte;
  assign pos_ext = {1'b0, pos};
  assign pos_inc = pos_ext + 18'd1;

  always_comb begin
    ipl_next = ipl;
    if (pos == 17'(POS_PLEN_HI)) ipl_next[15:8] = b;
    if (pos == 17'(POS_PLEN_LO)) ipl_next[7:0] = b;
    nh_next = (pos == 17'(POS_NEXT_HDR)) ? b : nh;
    kind = (pos >= 17'(POS_NEXT_HDR)) ? kind_of(nh_next) : KIND_OTHER;

    udpl_next  = udpl;
    found_next = found;
    if (kind == KIND_UDP) begin
      if (pos == 17'(POS_UDP_LEN_HI)) udpl_next[15:8] = b;
      if (pos == 17'(POS_UDP_LEN_LO)) udpl_next[7:0] = b;
      if (pos == 17'(POS_UDP_CS_HI)) found_next[15:8] = b;
      if (pos == 17'(POS_UDP_CS_LO)) found_next[7:0] = b;
    end else if (kind == KIND_ICMP6) begin
      if (pos == 17'(POS_ICMP_CS_HI)) found_next[15:8] = b;
      if (pos == 17'(POS_ICMP_CS_LO)) found_next[7:0] = b;
    end

    cur_in = in_sum(pos_ext, kind, udpl_next, ipl_next);
    nxt_in = in_sum(pos_inc, kind, udpl_next, ipl_next);

    // Even byte is held as the high half; flush it alone if the word ends here
    held_hi_next = held_hi;
    add_en       = 1'b0;
    addend       = '0;
    if (cur_in) begin
      if (!pos[0]) begin
        held_hi_next = b;
        if (!nxt_in) begin
          add_en = 1'b1;
          addend = {b, 8'h00};
        end
      end else begin
        add_en = 1'b1;
        addend = {held_hi, b};
      end
    end
    run_sum_next = add_en ? oc_add(run_sum, addend) : run_sum;
    pos_next     = (pos < POS_MAX) ? pos + 17'd1 : pos;

    udp_end = 18'(HDR_LEN) + {2'b00, udpl_next};
    ip_end  = 18'(HDR_LEN) + {2'b00, ipl_next};

    rec            = '0;
    rec.kind       = kind;
    rec.sum        = run_sum_next;
    rec.stored     = found_next;
    if (pos < 17'(POS_NEXT_HDR)) begin
      rec.status = ST_TRUNCATED;
      rec.kind   = KIND_OTHER;
      rec.offset = OFFSET_NONE;
    end else if (kind == KIND_UDP) begin
      rec.offset     = OFFSET_UDP;
      rec.pseudo_len = udpl_next;
      if (pos_inc < 18'(POS_UDP_CS_HI)) rec.status = ST_TRUNCATED;
      else if (udpl_next < 16'(UDP_MIN_LEN)) rec.status = ST_SHORT_UDP;
      else if (pos_inc < udp_end) rec.status = ST_TRUNCATED;
      else rec.status = ST_MATCH;
    end else if (kind == KIND_ICMP6) begin
      rec.offset     = OFFSET_ICMP6;
      rec.pseudo_len = ipl_next;
      if (ipl_next < 16'(ICMP_MIN_LEN) || pos_inc < ip_end) rec.status = ST_TRUNCATED;
      else rec.status = ST_MATCH;
    end else begin
      rec.status = ST_UNSUPPORTED;
      rec.offset = OFFSET_NONE;
    end
  end

  assign q_push = accept && item.last_byte;
  assign q_data = rec;

  always_ff @(posedge clk) begin
    if (rst || (accept && item.last_byte)) begin
      pos     <= '0;
      run_sum <= '0;
      held_hi <= '0;
      nh      <= '0;
      ipl     <= '0;
      udpl    <= '0;
      found   <= '0;
    end else if (accept) begin
      pos     <= pos_next;
      run_sum <= run_sum_next;
      held_hi <= held_hi_next;
      nh      <= nh_next;
      ipl     <= ipl_next;
      udpl    <= udpl_next;
      found   <= found_next;
    end
  end

endmodule

// ===== src/ip6cs_queue.sv =====
// ----------------------------------------------------------------------------
// IPv6 L4 checksum checker summary queue
// Small register queue of packet summaries between front and back.
// ----------------------------------------------------------------------------
module ip6cs_queue import ip6cs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  summary_t wr_data,
  input  logic     rd_en,
  output summary_t rd_data,
  output logic     full,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  summary_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_wr && !do_rd) count <= count + CNT_W'(1);
      else if (do_rd && !do_wr) count <= count - CNT_W'(1);
    end
  end

endmodule

// ===== src/ip6cs_back.sv =====
// ----------------------------------------------------------------------------
// IPv6 L4 checksum checker back end
// Adds the pseudo-header terms, applies the protocol zero rules, compares
// against the stored checksum and holds the result for the consumer.
// ----------------------------------------------------------------------------
module ip6cs_back import ip6cs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  summary_t  q_data,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t result
);

  logic        out_valid;
  logic [15:0] proto;
  logic [17:0] total;
  logic [16:0] fold1;
  logic [15:0] folded;
  logic [15:0] comp;
  logic [15:0] stored;
  out_item_t   res;

  // Load a new result when the slot is free or being emptied this cycle
  assign q_pop = !q_empty && (!out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    proto  = (q_data.kind == KIND_UDP) ? {8'h00, PROTO_UDP} : {8'h00, PROTO_ICMP6};
    total  = {2'b00, q_data.sum} + {2'b00, proto} + {2'b00, q_data.pseudo_len};
    fold1  = {1'b0, total[15:0]} + {15'b0, total[17:16]};
    folded = fold1[15:0] + {15'b0, fold1[16]};
    comp   = ~folded;
    stored = q_data.stored;
    if (q_data.kind == KIND_UDP) begin
      if (comp == '0) comp = ALL_ONES;
    end else begin
      if (comp == ALL_ONES) comp = '0;
      if (stored == ALL_ONES) stored = '0;
    end

    res.transport_kind  = q_data.kind;
    res.checksum_offset = q_data.offset;
    res.check_status    = q_data.status;
    if (q_data.status == ST_MATCH) begin
      res.computed_checksum = comp;
      res.stored_checksum   = stored;
      if (comp != stored) res.check_status = ST_MISMATCH;
    end else begin
      res.computed_checksum = '0;
      res.stored_checksum   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (q_pop) out_valid <= 1'b1;
    else if (pop) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) result <= res;
  end

endmodule

// ===== src/ipv6_l4_checksum_checker_core.sv =====
// ----------------------------------------------------------------------------
// IPv6 L4 checksum checker core
// Checks the UDP or ICMPv6 checksum of an IPv6 packet streamed bytewise.
// ----------------------------------------------------------------------------
// Input channel: one packet byte per transaction (push/full), starting at the
//   first byte of the IPv6 header; last_byte marks the final byte.
// Result channel (empty/pop): one result per packet, holding the computed
//   and stored checksums, status, transport kind and checksum offset.
// Throughput: one byte per cycle while full is low; the per-byte work is a single 16-bit
//   end-around add in the front end.
// Result path: the summary enters the queue at the edge that takes the last
//   byte, and moves into the back end result register once that register is
//   free or being popped.
// The summary queue holds QUEUE_DEPTH finished packets. If the consumer
//   stops popping, the result register and then the queue fill and full
//   rises; bytes are then held off until a result is popped.
// Reset clears position, sum and captured fields, empties the queue and
//   drops any waiting result.
// ----------------------------------------------------------------------------
module ipv6_l4_checksum_checker_core import ip6cs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic     accept;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  summary_t q_wr_data;
  summary_t q_rd_data;

  assign full   = q_full;
  assign accept = push && !q_full;

  ip6cs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  ip6cs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  ip6cs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ===== src/ip6cs_checker.sv =====
// ----------------------------------------------------------------------------
// IPv6 L4 checksum checker port checker
// Watches the result channel of the core and flags inconsistent results.
// ----------------------------------------------------------------------------
`include "ipv6_l4_checksum_checker_core_macros.svh"

module ip6cs_checker import ip6cs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  logic held;
  logic failed_status;
  logic sums_zero;
  logic offset_ok;

  assign held          = !empty && !pop;
  assign failed_status = (result.check_status == ST_UNSUPPORTED) ||
                         (result.check_status == ST_TRUNCATED) ||
                         (result.check_status == ST_SHORT_UDP);
  assign sums_zero     = (result.computed_checksum == '0) && (result.stored_checksum == '0);
  assign offset_ok     =
    (result.transport_kind == KIND_UDP && result.checksum_offset == OFFSET_UDP) ||
    (result.transport_kind == KIND_ICMP6 && result.checksum_offset == OFFSET_ICMP6) ||
    (result.transport_kind == KIND_OTHER && result.checksum_offset == OFFSET_NONE);

  `IP6CS_ASSERT_RESET(a_empty_after_reset, clk, rst, empty, "result queue not empty after reset")

  `IP6CS_ASSERT_NEXT(a_result_held, clk, rst, held, !empty && $stable(result), "waiting result changed")

  `IP6CS_ASSERT_SAME(a_status_range, clk, rst, !empty, result.check_status <= ST_SHORT_UDP, "status out of range")

  `IP6CS_ASSERT_SAME(a_failed_zero, clk, rst, !empty && failed_status, sums_zero, "checksums set on failed packet")

  `IP6CS_ASSERT_SAME(a_offset_kind, clk, rst, !empty, offset_ok, "offset does not match transport kind")

endmodule

bind ipv6_l4_checksum_checker_core ip6cs_checker u_ip6cs_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
